// ===== rtl/ssh_pkg.sv =====
// Shared types and constants for the speech segment hysteresis block.
// Holds the register map, reset values and the word formats used by core and queue.
package ssh_pkg;

    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_BITS      = 16;
    localparam int PROB_W        = 16;
    localparam int SEG_W         = 16;
    localparam int OUTQ_DEPTH    = 4;
    localparam int OUTQ_PTR_BITS = 2;
    localparam int OUTQ_CNT_BITS = 3;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_SPEECH_THR  = 3'd0,
        REG_RELEASE_THR = 3'd1,
        REG_MIN_SIL     = 3'd2,
        REG_MIN_SPEECH  = 3'd3,
        REG_PAD         = 3'd4
    } t_cfg_reg;

    localparam logic [CFG_BITS-1:0] RST_SPEECH_THR  = 16'd32768;
    localparam logic [CFG_BITS-1:0] RST_RELEASE_THR = 16'd22938;
    localparam logic [CFG_BITS-1:0] RST_MIN_SIL     = 16'd3;
    localparam logic [CFG_BITS-1:0] RST_MIN_SPEECH  = 16'd8;
    localparam logic [CFG_BITS-1:0] RST_PAD         = 16'd3;

    typedef struct packed {
        logic [CFG_BITS-1:0] speech_thr;
        logic [CFG_BITS-1:0] release_thr;
        logic [CFG_BITS-1:0] min_sil;
        logic [CFG_BITS-1:0] min_speech;
        logic [CFG_BITS-1:0] pad;
    } t_cfg;

    typedef struct packed {
        logic [SEG_W-1:0] seg_start;
        logic [SEG_W-1:0] seg_end;
        logic             reaches_end;
        logic             last_of_run;
    } t_seg_word;

    // Up to two result words per frame; cnt says how many are live, w0 first.
    typedef struct packed {
        t_seg_word   w0;
        t_seg_word   w1;
        logic [1:0]  cnt;
    } t_push;

endpackage

// ===== rtl/ssh_core.sv =====
// Per-frame segmentation state machine and result word generation.
// Depends on ssh_pkg for the configuration struct and result word formats.
module ssh_core import ssh_pkg::*; #(
    parameter int FRAME_INDEX_BITS = 16,
    parameter int PROB_BITS        = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_fire,
    input  logic [PROB_W-1:0] i_prob,
    input  logic              i_last,
    output t_push             o_push
);

    localparam int FB = FRAME_INDEX_BITS;
    localparam int CW = (FB > SEG_W) ? FB : SEG_W;
    localparam int EW = CW + 1;
    localparam int PW = (PROB_BITS < PROB_W) ? PROB_BITS : PROB_W;
    localparam logic [FB-1:0] FMAX = {FB{1'b1}};

    logic          r_in_speech, n_in_speech;
    logic          r_sil_act,   n_sil_act;
    logic          r_pend_valid, n_pend_valid;
    logic [FB-1:0] r_sp_start,  n_sp_start;
    logic [FB-1:0] r_sil_start, n_sil_start;
    logic [FB-1:0] r_frame,     n_frame;
    logic [CW-1:0] r_pend_start, n_pend_start;
    logic [EW-1:0] r_pend_end,   n_pend_end;

    logic          hi, below_rel, sil_done, close_main, do_close, keep, merge;
    logic [FB-1:0] count;
    logic [CW-1:0] close_end, s_x, pad_x, ps, seg_len;
    logic [EW-1:0] pe, e_clamp;
    logic          emit_a, emit_b;
    t_seg_word     word_a, word_b;

    always_comb begin
        hi        = i_prob[PW-1:0] >= i_cfg.speech_thr[PW-1:0];
        below_rel = i_prob[PW-1:0] <  i_cfg.release_thr[PW-1:0];
        sil_done  = (r_frame >= r_sil_start) &&
                    (CW'(r_frame - r_sil_start) >= CW'(i_cfg.min_sil));
        count     = (r_frame < FMAX) ? r_frame + FB'(1) : FMAX;

        n_in_speech  = r_in_speech;
        n_sil_act    = r_sil_act;
        n_pend_valid = r_pend_valid;
        n_sp_start   = r_sp_start;
        n_sil_start  = r_sil_start;
        n_frame      = r_frame;
        n_pend_start = r_pend_start;
        n_pend_end   = r_pend_end;
        close_main   = 1'b0;
        emit_a       = 1'b0;
        emit_b       = 1'b0;
        word_a       = '0;
        word_b       = '0;
        keep         = 1'b0;
        merge        = 1'b0;

        // Hysteresis: open on speech, arm a silence run below release.
        if (!r_in_speech) begin
            if (hi) begin
                n_in_speech = 1'b1;
                n_sp_start  = r_frame;
            end
        end else if (hi) begin
            n_sil_act = 1'b0;
        end else if (!r_sil_act) begin
            if (below_rel) begin
                n_sil_act   = 1'b1;
                n_sil_start = r_frame;
            end
        end else if (sil_done) begin
            close_main = 1'b1;
        end

        // One close per frame at most: by a long silence run or by the final frame.
        do_close = close_main || (i_last && n_in_speech);
        if (close_main)
            close_end = CW'(r_sil_start);
        else if (n_sil_act)
            close_end = CW'(n_sil_start);
        else
            close_end = CW'(count);

        s_x     = CW'(n_sp_start);
        pad_x   = CW'(i_cfg.pad);
        seg_len = close_end - s_x;
        ps      = (s_x > pad_x) ? s_x - pad_x : '0;
        pe      = EW'(close_end) + EW'(pad_x);

        if (do_close) begin
            n_in_speech = 1'b0;
            n_sil_act   = 1'b0;
            keep  = (close_end >= s_x) && (seg_len >= CW'(i_cfg.min_speech));
            merge = r_pend_valid && (EW'(ps) <= r_pend_end);
            if (keep) begin
                if (merge) begin
                    n_pend_end = pe;
                end else begin
                    emit_a             = r_pend_valid;
                    word_a.seg_start   = r_pend_start[SEG_W-1:0];
                    word_a.seg_end     = r_pend_end[SEG_W-1:0];
                    n_pend_valid       = 1'b1;
                    n_pend_start       = ps;
                    n_pend_end         = pe;
                end
            end
        end

        // Flush the pending segment with its end clamped at the frame count.
        e_clamp = (n_pend_end < EW'(count)) ? n_pend_end : EW'(count);
        if (i_last && n_pend_valid) begin
            emit_b             = 1'b1;
            word_b.seg_start   = n_pend_start[SEG_W-1:0];
            word_b.seg_end     = e_clamp[SEG_W-1:0];
            word_b.reaches_end = (e_clamp == EW'(count));
        end

        if (i_last) begin
            n_in_speech  = 1'b0;
            n_sil_act    = 1'b0;
            n_pend_valid = 1'b0;
            n_sp_start   = '0;
            n_sil_start  = '0;
            n_frame      = '0;
            n_pend_start = '0;
            n_pend_end   = '0;
        end else if (r_frame < FMAX) begin
            n_frame = r_frame + FB'(1);
        end

        word_a.last_of_run = !emit_b;
        word_b.last_of_run = 1'b1;

        o_push = '0;
        if (i_fire) begin
            if (emit_a) begin
                o_push.w0  = word_a;
                o_push.w1  = word_b;
                o_push.cnt = emit_b ? 2'd2 : 2'd1;
            end else if (emit_b) begin
                o_push.w0  = word_b;
                o_push.cnt = 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_speech  <= 1'b0;
            r_sil_act    <= 1'b0;
            r_pend_valid <= 1'b0;
            r_sp_start   <= '0;
            r_sil_start  <= '0;
            r_frame      <= '0;
            r_pend_start <= '0;
            r_pend_end   <= '0;
        end else if (i_fire) begin
            r_in_speech  <= n_in_speech;
            r_sil_act    <= n_sil_act;
            r_pend_valid <= n_pend_valid;
            r_sp_start   <= n_sp_start;
            r_sil_start  <= n_sil_start;
            r_frame      <= n_frame;
            r_pend_start <= n_pend_start;
            r_pend_end   <= n_pend_end;
        end
    end

endmodule

// ===== rtl/ssh_outq.sv =====
// Small result queue that takes up to two words per cycle and gives one while the reader does not stall.
// Depends on ssh_pkg for the word format and queue sizing.
module ssh_outq import ssh_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_push     i_push,
    output logic      o_room,
    output logic      o_valid,
    input  logic      i_stall,
    output t_seg_word o_word
);

    t_seg_word                r_mem [OUTQ_DEPTH];
    logic [OUTQ_PTR_BITS-1:0] r_wr_ptr, n_wr_ptr, wr_ptr1;
    logic [OUTQ_PTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [OUTQ_CNT_BITS-1:0] r_count, n_count;
    logic                     pop;

    always_comb begin
        pop      = (r_count != '0) && !i_stall;
        wr_ptr1  = r_wr_ptr + OUTQ_PTR_BITS'(1);
        n_wr_ptr = r_wr_ptr + OUTQ_PTR_BITS'(i_push.cnt);
        n_rd_ptr = r_rd_ptr + OUTQ_PTR_BITS'(pop);
        n_count  = r_count + OUTQ_CNT_BITS'(i_push.cnt) - OUTQ_CNT_BITS'(pop);
        o_valid  = (r_count != '0);
        o_room   = (r_count <= OUTQ_CNT_BITS'(OUTQ_DEPTH - 2));
        o_word   = r_mem[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0)
            r_mem[r_wr_ptr] <= i_push.w0;
        if (i_push.cnt == 2'd2)
            r_mem[wr_ptr1] <= i_push.w1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ===== rtl/speech_segment_hysteresis_top.sv =====
// Top level of the speech segment hysteresis block: configuration registers,
// segmentation core and result queue. Depends on ssh_pkg, ssh_core and ssh_outq.
//
// One speech probability word goes in per frame; padded, merged speech
// segments come out as (start, exclusive end) frame pairs. A frame is taken
// every clock while the result queue has room for two words: the whole
// per-frame update is combinational from the state registers, so the input
// rate is one frame per cycle. A frame yields zero, one or two result words
// (a pending segment pushed out by a new one, then the flush on the final
// frame); those words drain one per cycle, while the receiver does not stall,
// from a four-entry queue, so a sustained run of frames that each give two
// words is held back by the output side. last_of_run marks the final word a frame
// produces, and reaches_end marks a flushed segment that runs to the frame
// count. Frame indices saturate at 2^FRAME_INDEX_BITS-1. The end of
// recording resets the stream state but keeps the configuration. Write
// configuration only while no frame is in flight and the queue is empty.
module speech_segment_hysteresis_top import ssh_pkg::*; #(
    parameter int FRAME_INDEX_BITS = 16,
    parameter int PROB_BITS        = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration write port
    input  logic                     i_cfg_we,
    input  logic [CFG_ADDR_BITS-1:0] i_cfg_addr,
    input  logic [CFG_BITS-1:0]      i_cfg_data,
    // frame input channel
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [PROB_W-1:0]        i_prob,
    input  logic                     i_end_of_recording,
    // segment output channel
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [SEG_W-1:0]         o_seg_start,
    output logic [SEG_W-1:0]         o_seg_end,
    output logic                     o_reaches_end,
    output logic                     o_last_of_run
);

    t_cfg      r_cfg;
    t_push     push;
    t_seg_word q_word;
    logic      q_room;
    logic      in_fire;

    // Hold the upstream side whenever a frame's worth of words might not fit.
    assign o_stall = !q_room;
    assign in_fire = i_valid && q_room;

    // Register file; writes to unmapped indexes drop.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.speech_thr  <= RST_SPEECH_THR;
            r_cfg.release_thr <= RST_RELEASE_THR;
            r_cfg.min_sil     <= RST_MIN_SIL;
            r_cfg.min_speech  <= RST_MIN_SPEECH;
            r_cfg.pad         <= RST_PAD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_SPEECH_THR:  r_cfg.speech_thr  <= i_cfg_data;
                REG_RELEASE_THR: r_cfg.release_thr <= i_cfg_data;
                REG_MIN_SIL:     r_cfg.min_sil     <= i_cfg_data;
                REG_MIN_SPEECH:  r_cfg.min_speech  <= i_cfg_data;
                REG_PAD:         r_cfg.pad         <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ssh_core #(
        .FRAME_INDEX_BITS (FRAME_INDEX_BITS),
        .PROB_BITS        (PROB_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_fire  (in_fire),
        .i_prob  (i_prob),
        .i_last  (i_end_of_recording),
        .o_push  (push)
    );

    ssh_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (q_room),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_word  (q_word)
    );

    assign o_seg_start   = q_word.seg_start;
    assign o_seg_end     = q_word.seg_end;
    assign o_reaches_end = q_word.reaches_end;
    assign o_last_of_run = q_word.last_of_run;

endmodule

// ===== tb/sv/speech_segment_hysteresis_chk.sv =====
// Segment checker for the speech segment hysteresis testbench: predicts the segment
// words of every accepted frame and compares them with the words the block returns.
// Depends on ssh_pkg for the register map, the reset values and the word format.
module speech_segment_hysteresis_chk import ssh_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_ADDR_BITS-1:0] i_cfg_addr,
    input  logic [CFG_BITS-1:0]      i_cfg_data,
    input  logic                     i_frame_valid,
    input  logic                     i_frame_stall,
    input  logic [PROB_W-1:0]        i_prob,
    input  logic                     i_end_of_recording,
    input  logic                     i_seg_valid,
    input  logic                     i_seg_stall,
    input  logic [SEG_W-1:0]         i_seg_start,
    input  logic [SEG_W-1:0]         i_seg_end,
    input  logic                     i_reaches_end,
    input  logic                     i_last_of_run,
    output int                       o_err_count,
    output int                       o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [SEG_W-1:0] FRAME_CAP = '1;

    t_cfg             cfg;
    logic             in_speech;
    logic             silence_on;
    logic             pend_valid;
    logic [SEG_W-1:0] speech_from;
    logic [SEG_W-1:0] silence_from;
    logic [SEG_W-1:0] frame_no;
    logic [SEG_W-1:0] pend_start;
    logic [SEG_W:0]   pend_end;     // padded end, one bit wider before clamping

    t_seg_word        held_word;    // newest word of the current frame, not yet queued
    bit               held_live;
    t_seg_word        expected_segs[$];
    int               err_count = 0;

    assign o_err_count = err_count;

    task automatic report_mismatch(input string msg);
        err_count++;
        $display("%0t ns: segment check: %s", $time, msg);
    endtask

    function automatic void clear_stream();
        in_speech    = 1'b0;
        silence_on   = 1'b0;
        pend_valid   = 1'b0;
        speech_from  = '0;
        silence_from = '0;
        frame_no     = '0;
        pend_start   = '0;
        pend_end     = '0;
    endfunction

    function automatic void queue_word(input logic [SEG_W-1:0] s, input logic [SEG_W-1:0] e,
                                       input logic reach);
        if (held_live)
            expected_segs.push_back(held_word);
        held_word = '{seg_start: s, seg_end: e, reaches_end: reach, last_of_run: 1'b0};
        held_live = 1'b1;
    endfunction

    // Close the open segment at end_f; keep it only if long enough, then pad and merge.
    function automatic void close_segment_at(input logic [SEG_W-1:0] end_f);
        logic [SEG_W-1:0] pad_start;
        logic [SEG_W:0]   pad_end;
        in_speech  = 1'b0;
        silence_on = 1'b0;
        if (end_f >= speech_from && (end_f - speech_from) >= cfg.min_speech) begin
            pad_start = (speech_from > cfg.pad) ? speech_from - cfg.pad : '0;
            pad_end   = {1'b0, end_f} + {1'b0, cfg.pad};
            if (pend_valid && {1'b0, pad_start} <= pend_end) begin
                pend_end = pad_end;
            end else begin
                if (pend_valid)
                    queue_word(pend_start, pend_end[SEG_W-1:0], 1'b0);
                pend_valid = 1'b1;
                pend_start = pad_start;
                pend_end   = pad_end;
            end
        end
    endfunction

    function automatic void predict_frame(input logic [PROB_W-1:0] prob, input logic last);
        logic [SEG_W-1:0] f;
        logic [SEG_W-1:0] count;
        logic [SEG_W:0]   clamped;
        logic             hi;
        f  = frame_no;
        hi = prob >= cfg.speech_thr;
        held_live = 1'b0;

        if (!in_speech) begin
            if (hi) begin
                in_speech   = 1'b1;
                speech_from = f;
            end
        end else if (hi) begin
            silence_on = 1'b0;
        end else if (!silence_on) begin
            if (prob < cfg.release_thr) begin
                silence_on   = 1'b1;
                silence_from = f;
            end
        end else if (f >= silence_from && (f - silence_from) >= cfg.min_sil) begin
            close_segment_at(silence_from);
        end

        if (last) begin
            count = (f < FRAME_CAP) ? f + 1'b1 : FRAME_CAP;
            if (in_speech)
                close_segment_at(silence_on ? silence_from : count);
            if (pend_valid) begin
                clamped = (pend_end < {1'b0, count}) ? pend_end : {1'b0, count};
                queue_word(pend_start, clamped[SEG_W-1:0], clamped == {1'b0, count});
            end
            clear_stream();
        end else if (frame_no < FRAME_CAP) begin
            frame_no = frame_no + 1'b1;
        end

        if (held_live) begin
            held_word.last_of_run = 1'b1;
            expected_segs.push_back(held_word);
            held_live = 1'b0;
        end
    endfunction

    always @(posedge i_clk) begin
        t_seg_word want;
        if (!i_rst_n) begin
            cfg = '{speech_thr: RST_SPEECH_THR, release_thr: RST_RELEASE_THR,
                    min_sil: RST_MIN_SIL, min_speech: RST_MIN_SPEECH, pad: RST_PAD};
            clear_stream();
            expected_segs.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_SPEECH_THR:  cfg.speech_thr  = i_cfg_data;
                    REG_RELEASE_THR: cfg.release_thr = i_cfg_data;
                    REG_MIN_SIL:     cfg.min_sil     = i_cfg_data;
                    REG_MIN_SPEECH:  cfg.min_speech  = i_cfg_data;
                    REG_PAD:         cfg.pad         = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_frame_valid && !i_frame_stall)
                predict_frame(i_prob, i_end_of_recording);
            if (i_seg_valid && !i_seg_stall) begin
                if (expected_segs.size() == 0) begin
                    report_mismatch($sformatf("word start %0d end %0d with none expected",
                                              i_seg_start, i_seg_end));
                end else begin
                    want = expected_segs.pop_front();
                    if (i_seg_start !== want.seg_start)
                        report_mismatch($sformatf("seg_start %0d, expected %0d",
                                                  i_seg_start, want.seg_start));
                    if (i_seg_end !== want.seg_end)
                        report_mismatch($sformatf("seg_end %0d, expected %0d",
                                                  i_seg_end, want.seg_end));
                    if (i_reaches_end !== want.reaches_end)
                        report_mismatch($sformatf("reaches_end %0b, expected %0b",
                                                  i_reaches_end, want.reaches_end));
                    if (i_last_of_run !== want.last_of_run)
                        report_mismatch($sformatf("last_of_run %0b, expected %0b",
                                                  i_last_of_run, want.last_of_run));
                end
            end
        end
        o_outstanding <= expected_segs.size();
    end

endmodule

// ===== tb/sv/speech_segment_hysteresis_top_tb.sv =====
// Testbench top for speech_segment_hysteresis_top: clock, reset, frame and
// configuration stimulus, output stalls, watchdog and verdict.
// Depends on ssh_pkg, the block's RTL and speech_segment_hysteresis_chk.
module speech_segment_hysteresis_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ssh_pkg::*;

    localparam int RESET_CYCLES   = 12;
    localparam int RANDOM_FRAMES  = 1520;   // frames of the random part
    localparam int QUIET_TAIL     = 250;    // last frames run with no idling at all
    localparam int RECS_PER_CFG   = 6;
    localparam int SETTLE_CYCLES  = 8;      // frames that give no word may still be in flight
    localparam int DRAIN_CYCLES   = 16;
    // Longest legal quiet stretch: a sender gap on top of a receiver stall, or a
    // configuration load after a drain. Take it many times over.
    localparam int WATCHDOG_LIMIT = 4000;
    // Indexes outside the register map; writes to them must change nothing.
    localparam logic [CFG_ADDR_BITS-1:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_ADDR_BITS-1:0] REG_SPARE_LAST  = 3'd7;

    typedef enum int {FK_SPEECH, FK_QUIET, FK_BAND, FK_NOISE} t_frame_kind;

    // Every input starts at a known value.
    logic                     i_clk              = 1'b0;
    logic                     i_rst_n            = 1'b0;
    logic                     i_cfg_we           = 1'b0;
    logic [CFG_ADDR_BITS-1:0] i_cfg_addr         = '0;
    logic [CFG_BITS-1:0]      i_cfg_data         = '0;
    logic                     i_valid            = 1'b0;
    logic [PROB_W-1:0]        i_prob             = '0;
    logic                     i_end_of_recording = 1'b0;
    logic                     i_stall            = 1'b0;
    logic                     o_stall;
    logic                     o_valid;
    logic [SEG_W-1:0]         o_seg_start;
    logic [SEG_W-1:0]         o_seg_end;
    logic                     o_reaches_end;
    logic                     o_last_of_run;

    int err_count;
    int outstanding;
    int quiet_cycles = 0;
    int rnd_frames   = 0;
    bit send_gaps    = 1'b0;
    bit recv_gaps    = 1'b0;

    // Stimulus-side copy of the live settings; it only shapes the probabilities.
    int cur_thr = int'(RST_SPEECH_THR);
    int cur_rel = int'(RST_RELEASE_THR);
    int cur_sil = int'(RST_MIN_SIL);
    int cur_sp  = int'(RST_MIN_SPEECH);

    speech_segment_hysteresis_top DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_addr         (i_cfg_addr),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_prob             (i_prob),
        .i_end_of_recording (i_end_of_recording),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_seg_start        (o_seg_start),
        .o_seg_end          (o_seg_end),
        .o_reaches_end      (o_reaches_end),
        .o_last_of_run      (o_last_of_run)
    );

    speech_segment_hysteresis_chk seg_chk (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_addr         (i_cfg_addr),
        .i_cfg_data         (i_cfg_data),
        .i_frame_valid      (i_valid),
        .i_frame_stall      (o_stall),
        .i_prob             (i_prob),
        .i_end_of_recording (i_end_of_recording),
        .i_seg_valid        (o_valid),
        .i_seg_stall        (i_stall),
        .i_seg_start        (o_seg_start),
        .i_seg_end          (o_seg_end),
        .i_reaches_end      (o_reaches_end),
        .i_last_of_run      (o_last_of_run),
        .o_err_count        (err_count),
        .o_outstanding      (outstanding)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Receiver side: stall in bursts of random length while enabled.
    always begin
        @(negedge i_clk);
        if (recv_gaps && $urandom_range(0, 5) == 0) begin
            i_stall <= 1'b1;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
            i_stall <= 1'b0;
        end
    end

    // Watchdog: any handshake, register write or reset cycle restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("speech_segment_hysteresis_top_tb: errors");
            $finish;
        end
    end

    // Present one frame word at the falling edge and hold it until accepted.
    // Stall is sampled at the rising edge, before the block updates it.
    task automatic send_frame(input logic [PROB_W-1:0] prob, input logic last);
        if (send_gaps && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        i_valid            <= 1'b1;
        i_prob             <= prob;
        i_end_of_recording <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Hold the sender until every predicted word has come back; always wait for
    // a falling edge first so valid never drops and rises in one step.
    task automatic wait_drained();
        do @(negedge i_clk); while (outstanding != 0);
    endtask

    task automatic put_reg(input logic [CFG_ADDR_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
    endtask

    // Reprogram all five registers with the block idle, plus one write to an
    // unmapped index that must be ignored.
    task automatic load_config(input logic [CFG_BITS-1:0] thr, input logic [CFG_BITS-1:0] rel,
                               input logic [CFG_BITS-1:0] sil, input logic [CFG_BITS-1:0] minsp,
                               input logic [CFG_BITS-1:0] pad);
        i_valid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        put_reg(REG_SPEECH_THR, thr);
        put_reg(REG_RELEASE_THR, rel);
        put_reg(REG_MIN_SIL, sil);
        put_reg(REG_MIN_SPEECH, minsp);
        put_reg(REG_PAD, pad);
        put_reg(CFG_ADDR_BITS'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                CFG_BITS'($urandom));
        i_cfg_we <= 1'b0;
        cur_thr = int'(thr);
        cur_rel = int'(rel);
        cur_sil = int'(sil);
        cur_sp  = int'(minsp);
    endtask

    // One recording: alternating speech and quiet runs sized around the current
    // minimum lengths, salted with hysteresis-band and fully random frames.
    // The final frame carries end_of_recording. pause_at >= 0 drains mid-stream.
    task automatic send_recording(input int len, input int pause_at);
        int               run_left;
        int               idx;
        int               roll;
        bit               talking;
        t_frame_kind      kind;
        logic [PROB_W-1:0] prob;
        run_left = 0;
        talking  = 1'($urandom_range(0, 1));
        for (idx = 0; idx < len; idx++) begin
            if (run_left == 0) begin
                talking  = !talking;
                run_left = talking ? $urandom_range(1, cur_sp + 4)
                                   : $urandom_range(1, cur_sil + 4);
            end
            run_left--;
            roll = $urandom_range(0, 19);
            if (roll == 0)
                kind = FK_NOISE;
            else if (roll < 3)
                kind = FK_BAND;
            else
                kind = talking ? FK_SPEECH : FK_QUIET;
            case (kind)
                FK_SPEECH: prob = PROB_W'($urandom_range(32'hFFFF, cur_thr));
                FK_QUIET:  prob = (cur_rel == 0) ? '0
                                                 : PROB_W'($urandom_range(cur_rel - 1, 0));
                FK_BAND:   prob = (cur_rel < cur_thr)
                                ? PROB_W'($urandom_range(cur_thr - 1, cur_rel))
                                : PROB_W'($urandom);
                default:   prob = PROB_W'($urandom);
            endcase
            send_frame(prob, idx == len - 1);
            rnd_frames++;
            if (idx == pause_at) begin
                i_valid <= 1'b0;
                wait_drained();
            end
        end
    endtask

    initial begin
        int               rec_no;
        int               len;
        int               thr;
        int               rel;
        bit               tail;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part, reset settings.
        // Final frame with nothing pending: no word at all.
        send_frame(16'h0000, 1'b1);
        // Open exactly at the speech threshold; values just under the threshold
        // and right at the release threshold must not start a silence run; the
        // value just under release does, and three quiet frames close the segment.
        // Then a short segment at the end is dropped and the kept one is flushed.
        send_frame(RST_SPEECH_THR, 1'b0);
        repeat (7) send_frame(16'hFFFF, 1'b0);
        send_frame(RST_SPEECH_THR - 1'b1, 1'b0);
        send_frame(RST_RELEASE_THR, 1'b0);
        send_frame(RST_RELEASE_THR - 1'b1, 1'b0);
        repeat (3) send_frame(16'h0000, 1'b0);
        send_frame(16'hFFFF, 1'b0);
        send_frame(16'h0000, 1'b1);
        // Open segment still talking on the final frame: clamp at the frame count.
        send_frame(16'h0000, 1'b0);
        repeat (7) send_frame(16'hFFFF, 1'b0);
        send_frame(16'hFFFF, 1'b1);

        // Extreme settings: everything zero, everything at maximum, and a
        // release threshold above the speech threshold with maximal padding.
        send_gaps = 1'b1;
        recv_gaps = 1'b1;
        load_config('0, '0, '0, '0, '0);
        repeat (4) send_recording($urandom_range(8, 40), -1);
        load_config('1, '1, '1, '1, '1);
        repeat (4) send_recording($urandom_range(8, 40), -1);
        load_config(16'd40000, '1, '0, '0, '1);
        repeat (4) send_recording($urandom_range(8, 40), -1);

        // Random part: fresh settings every few recordings, idling switched on
        // and off per recording, and no idling at all in the tail.
        rec_no = 0;
        while (rnd_frames < RANDOM_FRAMES) begin
            tail = (rnd_frames >= RANDOM_FRAMES - QUIET_TAIL);
            if (tail) begin
                send_gaps = 1'b0;
                recv_gaps = 1'b0;
            end else begin
                if (rec_no % RECS_PER_CFG == 0) begin
                    thr = $urandom_range(1, 16'hFFFF);
                    rel = ($urandom_range(0, 3) == 0) ? $urandom_range(16'hFFFF, 0)
                                                      : $urandom_range(thr, 0);
                    load_config(CFG_BITS'(thr), CFG_BITS'(rel),
                                CFG_BITS'($urandom_range(0, 6)),
                                CFG_BITS'($urandom_range(0, 12)),
                                CFG_BITS'($urandom_range(0, 8)));
                end
                send_gaps = ($urandom_range(0, 3) != 0);
                recv_gaps = ($urandom_range(0, 3) != 0);
            end
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(8, 60);
            // Drain in mid-recording on the first one, then now and then.
            if (tail)
                send_recording(len, -1);
            else if (rec_no == 0)
                send_recording(len, len / 2);
            else if ($urandom_range(0, 9) == 0)
                send_recording(len, $urandom_range(0, len - 1));
            else
                send_recording(len, -1);
            rec_no++;
        end

        i_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0)
            $display("speech_segment_hysteresis_top_tb: clean");
        else
            $display("speech_segment_hysteresis_top_tb: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ssh_pkg.sv
rtl/ssh_core.sv
rtl/ssh_outq.sv
rtl/speech_segment_hysteresis_top.sv
tb/sv/speech_segment_hysteresis_chk.sv
tb/sv/speech_segment_hysteresis_top_tb.sv
